### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms used by the checker of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/clt_pkg.sv
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Result kinds, tokenizer phases, special bytes and the result bundle passed to the queue.
// ----------------------------------------------------------------------------
package clt_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_WORD_END = 2'd1;
  localparam logic [1:0] KIND_LINE_END = 2'd2;

  // Tokenizer phases.
  localparam logic [1:0] PHASE_BETWEEN = 2'd0;
  localparam logic [1:0] PHASE_IN_WORD = 2'd1;
  localparam logic [1:0] PHASE_IGNORE  = 2'd2;

  // Special bytes.
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LOWER_N = 8'h6e;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;

  // Octal digit count at which the next digit completes an escape.
  localparam logic [1:0] OCTAL_LAST = 2'd2;

  // One result without its word count.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } result_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [1:0]       cnt;
    result_t [2:0]    res;
    logic [6:0]       word_count;
  } bundle_t;

endpackage

### hw/rtl/clt_front.sv
// ----------------------------------------------------------------------------
// Tokenizer front end
// Accepts one byte per cycle while the queue is not full, tracks the word state
// and builds the bundle of results that the byte causes.
// ----------------------------------------------------------------------------
module clt_front #(
  parameter int MAX_WORDS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             ch_valid,
  input  logic [7:0]       ch,
  input  logic             q_full,
  output logic             ch_stall,
  output logic             push,
  output clt_pkg::bundle_t push_data
);

  logic [1:0] phase, phase_next;
  logic [7:0] quote_char, quote_next;
  logic       escape_pending, esc_next;
  logic [1:0] octal_digits, odig_next;
  logic [7:0] octal_value, oval_next;
  logic [6:0] words_seen, words_next;

  logic       accept;
  logic       is_end, is_blank, is_oct, go, word_ok;
  logic [1:0] n;
  clt_pkg::bundle_t bnd;

  assign accept   = ch_valid && !q_full;
  assign ch_stall = q_full;
  assign push     = accept && (bnd.cnt != 2'd0);
  assign push_data = bnd;

  assign is_end   = (ch == clt_pkg::CH_NL) || (ch == clt_pkg::CH_NUL);
  assign is_blank = (ch == clt_pkg::CH_SPACE) || (ch == clt_pkg::CH_TAB);
  assign is_oct   = (ch >= clt_pkg::CH_ZERO) && (ch <= clt_pkg::CH_SEVEN);

  // Next state and the results of the current byte.
  always_comb begin
    phase_next = phase;
    quote_next = quote_char;
    esc_next   = escape_pending;
    odig_next  = octal_digits;
    oval_next  = octal_value;
    words_next = words_seen;
    bnd        = '0;
    n          = 2'd0;
    go         = 1'b1;
    word_ok    = 1'b1;

    if (is_end) begin
      // Flush the octal byte, close the word, then report the line end.
      if (octal_digits != 2'd0) begin
        bnd.res[n] = '{kind: clt_pkg::KIND_BYTE, value: octal_value};
        n = n + 2'd1;
      end
      if (phase == clt_pkg::PHASE_IN_WORD) begin
        bnd.res[n] = '{kind: clt_pkg::KIND_WORD_END, value: 8'd0};
        n = n + 2'd1;
      end
      bnd.res[n] = '{kind: clt_pkg::KIND_LINE_END, value: 8'd0};
      n = n + 2'd1;
      bnd.word_count = words_seen;
      phase_next = clt_pkg::PHASE_BETWEEN;
      quote_next = 8'd0;
      esc_next   = 1'b0;
      odig_next  = 2'd0;
      oval_next  = 8'd0;
      words_next = 7'd0;
    end else if (phase != clt_pkg::PHASE_IGNORE) begin
      // An octal escape in progress takes digits or is flushed.
      if (octal_digits != 2'd0) begin
        if (is_oct) begin
          oval_next = {octal_value[4:0], ch[2:0]};
          if (octal_digits == clt_pkg::OCTAL_LAST) begin
            bnd.res[n] = '{kind: clt_pkg::KIND_BYTE, value: oval_next};
            n = n + 2'd1;
            odig_next = 2'd0;
            oval_next = 8'd0;
          end else begin
            odig_next = octal_digits + 2'd1;
          end
          go = 1'b0;
        end else begin
          bnd.res[n] = '{kind: clt_pkg::KIND_BYTE, value: octal_value};
          n = n + 2'd1;
          odig_next = 2'd0;
          oval_next = 8'd0;
        end
      end

      if (go) begin
        // Between words a byte may start a word or the ignored tail.
        if (phase == clt_pkg::PHASE_BETWEEN) begin
          if (is_blank) begin
            word_ok = 1'b0;
          end else if ((ch == clt_pkg::CH_HASH) || (words_seen >= 7'(MAX_WORDS))) begin
            phase_next = clt_pkg::PHASE_IGNORE;
            word_ok    = 1'b0;
          end else begin
            words_next = words_seen + 7'd1;
            phase_next = clt_pkg::PHASE_IN_WORD;
          end
        end

        // Byte inside a word.
        if (word_ok) begin
          if (escape_pending) begin
            esc_next = 1'b0;
            if (ch == clt_pkg::CH_LOWER_N) begin
              bnd.res[n] = '{kind: clt_pkg::KIND_BYTE, value: clt_pkg::CH_NL};
              n = n + 2'd1;
            end else if (ch == clt_pkg::CH_LOWER_R) begin
              bnd.res[n] = '{kind: clt_pkg::KIND_BYTE, value: clt_pkg::CH_CR};
              n = n + 2'd1;
            end else if (is_oct) begin
              oval_next = {5'd0, ch[2:0]};
              odig_next = 2'd1;
            end else begin
              bnd.res[n] = '{kind: clt_pkg::KIND_BYTE, value: ch};
              n = n + 2'd1;
            end
          end else if (ch == clt_pkg::CH_BSLASH) begin
            esc_next = 1'b1;
          end else if (quote_char != 8'd0) begin
            if (ch == quote_char) begin
              quote_next = 8'd0;
            end else begin
              bnd.res[n] = '{kind: clt_pkg::KIND_BYTE, value: ch};
              n = n + 2'd1;
            end
          end else if ((ch == clt_pkg::CH_DQUOTE) || (ch == clt_pkg::CH_SQUOTE)) begin
            quote_next = ch;
          end else if (is_blank) begin
            bnd.res[n] = '{kind: clt_pkg::KIND_WORD_END, value: 8'd0};
            n = n + 2'd1;
            phase_next = clt_pkg::PHASE_BETWEEN;
          end else begin
            bnd.res[n] = '{kind: clt_pkg::KIND_BYTE, value: ch};
            n = n + 2'd1;
          end
        end
      end
    end

    bnd.cnt = n;
  end

  // State registers advance on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= clt_pkg::PHASE_BETWEEN;
      quote_char     <= 8'd0;
      escape_pending <= 1'b0;
      octal_digits   <= 2'd0;
      octal_value    <= 8'd0;
      words_seen     <= 7'd0;
    end else if (accept) begin
      phase          <= phase_next;
      quote_char     <= quote_next;
      escape_pending <= esc_next;
      octal_digits   <= odig_next;
      octal_value    <= oval_next;
      words_seen     <= words_next;
    end
  end

endmodule

### hw/rtl/clt_queue.sv
// ----------------------------------------------------------------------------
// Tokenizer bundle queue
// Small first-in first-out buffer of result bundles between front and back.
// ----------------------------------------------------------------------------
module clt_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  clt_pkg::bundle_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output clt_pkg::bundle_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  clt_pkg::bundle_t store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign head  = store[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/clt_back.sv
// ----------------------------------------------------------------------------
// Tokenizer back end
// Unpacks queued bundles into single results held in an output register.
// ----------------------------------------------------------------------------
module clt_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  clt_pkg::bundle_t head,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [1:0]       kind,
  output logic [7:0]       value,
  output logic [6:0]       word_count,
  output logic             last
);

  logic [1:0]        idx;
  logic              load, final_sel;
  clt_pkg::result_t  cur;

  assign load      = !empty && (!res_valid || !res_stall);
  assign final_sel = (idx == head.cnt - 2'd1);
  assign pop       = load && final_sel;
  assign cur       = head.res[idx];

  // Output valid and position within the bundle.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      res_valid <= 1'b1;
      idx       <= final_sel ? 2'd0 : idx + 2'd1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      kind       <= cur.kind;
      value      <= cur.value;
      word_count <= (cur.kind == clt_pkg::KIND_LINE_END) ? head.word_count : 7'd0;
      last       <= final_sel;
    end
  end

endmodule

### hw/rtl/command_line_tokenizer_core.sv
// A byte's first result passes through the bundle queue and then the output register.
// Throughput: one byte per cycle; the result port gives one result per cycle while
// res_stall is low, so bytes with two or three results are absorbed by the QUEUE_DEPTH
// bundle queue and the input stalls only when that queue is full.
// Reset: synchronous rst returns the tokenizer to between words, empties the
// queue and drops the output register.
// ----------------------------------------------------------------------------
// Command line tokenizer core
// Splits a command line, one byte per request, into word bytes, word ends and
// a line end carrying the word count.
// ----------------------------------------------------------------------------
module command_line_tokenizer_core #(
  parameter int MAX_WORDS   = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       ch_valid,
  output logic       ch_stall,
  input  logic [7:0] ch,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] kind,
  output logic [7:0] value,
  output logic [6:0] word_count,
  output logic       last
);

  logic             push, pop, q_full, q_empty;
  clt_pkg::bundle_t push_data, head;

  // Classification and word state.
  clt_front #(.MAX_WORDS(MAX_WORDS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .ch_valid  (ch_valid),
    .ch        (ch),
    .q_full    (q_full),
    .ch_stall  (ch_stall),
    .push      (push),
    .push_data (push_data)
  );

  // Decoupling queue.
  clt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  // Result serialization.
  clt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (q_empty),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .kind       (kind),
    .value      (value),
    .word_count (word_count),
    .last       (last)
  );

endmodule

### hw/rtl/clt_checker.sv
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Watches the result port of the tokenizer core and flags malformed results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clt_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_stall,
  input logic [1:0] kind,
  input logic [7:0] value,
  input logic [6:0] word_count,
  input logic       last
);

  // A stalled result stays put.
  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable({kind, value, word_count, last}))

  // A line end always closes the results of its byte.
  `ASSERT_IMPLY(a_line_end_last, clk, rst, res_valid && (kind == clt_pkg::KIND_LINE_END), last)

  // Only line ends carry a word count.
  `ASSERT_IMPLY(a_count_zero, clk, rst, res_valid && (kind != clt_pkg::KIND_LINE_END), word_count == 7'd0)

  // Only word bytes carry a value.
  `ASSERT_IMPLY(a_value_zero, clk, rst, res_valid && (kind != clt_pkg::KIND_BYTE), value == 8'd0)

endmodule

bind command_line_tokenizer_core clt_checker u_clt_checker (.*);

### bench/command_line_tokenizer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line tokenizer core testbench
// Feeds command lines one byte per request and checks every word byte, word
// end and line end against a cycle-free model of the tokenizer. A short table
// of directed requests and a line past the word limit come first, then random lines
// under three patterns of sender and receiver idling, the last with one long receiver hold-off.
// ----------------------------------------------------------------------------
module command_line_tokenizer_core_test;

  localparam int MAX_WORDS   = 64;
  localparam int OCTAL_RUN   = 3;
  localparam int DIR_ROWS    = 28;
  localparam int PHASE_ITEMS = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;

  // One result of the tokenizer as seen on the result port.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [6:0] word_cnt;
    logic       last;
  } token_t;

  // One row of the directed table; typed rows carry their own results.
  typedef struct packed {
    logic [7:0]       ch;
    logic             typed;
    logic [1:0]       n_res;
    token_t [2:0]     res;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       ch_valid = 1'b0;
  logic       ch_stall;
  logic [7:0] ch = 8'h00;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] value;
  logic [6:0] word_count;
  logic       last;

  // Tokenizer model state.
  logic [1:0] tok_phase;
  logic [7:0] open_quote;
  logic       esc_open;
  int         oct_digits;
  logic [7:0] oct_value;
  logic [6:0] words_started;

  token_t     step_tokens[$];
  token_t     expected_tokens[$];
  logic [7:0] line_bytes[$];
  dir_row_t   dir_table [0:DIR_ROWS-1];
  token_t     arrived_want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_epoch = 0;
  int counted_items = 0;
  int error_count = 0;
  int cycle_count = 0;

  command_line_tokenizer_core #(
    .MAX_WORDS(MAX_WORDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .ch_valid(ch_valid),
    .ch_stall(ch_stall),
    .ch(ch),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .kind(kind),
    .value(value),
    .word_count(word_count),
    .last(last)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic token_t tok(logic [1:0] k, logic [7:0] v, logic [6:0] n, logic l);
    token_t t;
    t.kind = k;
    t.value = v;
    t.word_cnt = n;
    t.last = l;
    return t;
  endfunction

  function automatic dir_row_t plain_row(logic [7:0] c);
    dir_row_t r;
    r = '0;
    r.ch = c;
    return r;
  endfunction

  function automatic dir_row_t typed_row(logic [7:0] c, logic [1:0] n, token_t t0);
    dir_row_t r;
    r = '0;
    r.ch = c;
    r.typed = 1'b1;
    r.n_res = n;
    r.res[0] = t0;
    return r;
  endfunction

  function automatic logic is_octal(logic [7:0] c);
    return c >= clt_pkg::CH_ZERO && c <= clt_pkg::CH_SEVEN;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == clt_pkg::CH_SPACE || c == clt_pkg::CH_TAB;
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  task automatic clear_tokenizer();
    tok_phase = clt_pkg::PHASE_BETWEEN;
    open_quote = 8'h00;
    esc_open = 1'b0;
    oct_digits = 0;
    oct_value = 8'h00;
    words_started = 7'd0;
  endtask

  // At most three results leave the tokenizer for one byte.
  task automatic emit_token(logic [1:0] k, logic [7:0] v, logic [6:0] n);
    if (step_tokens.size() < 3) step_tokens.push_back(tok(k, v, n, 1'b0));
  endtask

  // Handling of a byte that belongs to an open word.
  task automatic word_byte(logic [7:0] c);
    if (esc_open) begin
      esc_open = 1'b0;
      if (c == clt_pkg::CH_LOWER_N) emit_token(clt_pkg::KIND_BYTE, clt_pkg::CH_NL, 7'd0);
      else if (c == clt_pkg::CH_LOWER_R) emit_token(clt_pkg::KIND_BYTE, clt_pkg::CH_CR, 7'd0);
      else if (is_octal(c)) begin
        oct_value = {5'd0, c[2:0]};
        oct_digits = 1;
      end else emit_token(clt_pkg::KIND_BYTE, c, 7'd0);
    end else if (c == clt_pkg::CH_BSLASH) begin
      esc_open = 1'b1;
    end else if (open_quote != 8'h00) begin
      if (c == open_quote) open_quote = 8'h00;
      else emit_token(clt_pkg::KIND_BYTE, c, 7'd0);
    end else if (c == clt_pkg::CH_DQUOTE || c == clt_pkg::CH_SQUOTE) begin
      open_quote = c;
    end else if (is_blank(c)) begin
      emit_token(clt_pkg::KIND_WORD_END, 8'h00, 7'd0);
      tok_phase = clt_pkg::PHASE_BETWEEN;
    end else begin
      emit_token(clt_pkg::KIND_BYTE, c, 7'd0);
    end
  endtask

  // Advances the model by one byte and collects its results in step_tokens.
  task automatic tokenize_byte(logic [7:0] c);
    logic take;
    take = 1'b1;
    if (c == clt_pkg::CH_NL || c == clt_pkg::CH_NUL) begin
      if (oct_digits != 0) emit_token(clt_pkg::KIND_BYTE, oct_value, 7'd0);
      if (tok_phase == clt_pkg::PHASE_IN_WORD) begin
        emit_token(clt_pkg::KIND_WORD_END, 8'h00, 7'd0);
      end
      emit_token(clt_pkg::KIND_LINE_END, 8'h00, words_started);
      clear_tokenizer();
    end else if (tok_phase != clt_pkg::PHASE_IGNORE) begin
      // A pending octal escape either grows or is flushed first.
      if (oct_digits != 0) begin
        if (is_octal(c)) begin
          oct_value = {oct_value[4:0], c[2:0]};
          oct_digits++;
          if (oct_digits >= OCTAL_RUN) begin
            emit_token(clt_pkg::KIND_BYTE, oct_value, 7'd0);
            oct_digits = 0;
            oct_value = 8'h00;
          end
          take = 1'b0;
        end else begin
          emit_token(clt_pkg::KIND_BYTE, oct_value, 7'd0);
          oct_digits = 0;
          oct_value = 8'h00;
        end
      end
      // Between words a byte may start a word, a comment or the overflow.
      if (take && tok_phase == clt_pkg::PHASE_BETWEEN) begin
        if (is_blank(c)) begin
          take = 1'b0;
        end else if (c == clt_pkg::CH_HASH || words_started >= MAX_WORDS) begin
          tok_phase = clt_pkg::PHASE_IGNORE;
          take = 1'b0;
        end else begin
          words_started = words_started + 7'd1;
          tok_phase = clt_pkg::PHASE_IN_WORD;
        end
      end
      if (take) word_byte(c);
    end
  endtask

  // Queues the expected results of one request, then offers it to the block.
  task automatic send_request(dir_row_t r);
    logic   skipped;
    token_t t;
    step_tokens.delete();
    skipped = tok_phase == clt_pkg::PHASE_IGNORE && r.ch != clt_pkg::CH_NL &&
              r.ch != clt_pkg::CH_NUL;
    tokenize_byte(r.ch);
    if (r.typed) begin
      step_tokens.delete();
      for (int i = 0; i < r.n_res; i++) step_tokens.push_back(r.res[i]);
    end else if (step_tokens.size() > 0) begin
      t = step_tokens.pop_back();
      t.last = 1'b1;
      step_tokens.push_back(t);
    end
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    if (!skipped) counted_items++;

    while ($urandom_range(99) < send_idle_pct) begin
      ch_valid <= 1'b0;
      ch <= 8'($urandom_range(255));
      @(posedge clk);
    end
    ch_valid <= 1'b1;
    ch <= r.ch;
    @(posedge clk);
    while (ch_stall) @(posedge clk);
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_request(plain_row(line_bytes[i]));
    line_bytes.delete();
  endtask

  task automatic add_blanks();
    repeat ($urandom_range(1, 3)) begin
      line_bytes.push_back($urandom_range(1) ? clt_pkg::CH_SPACE : clt_pkg::CH_TAB);
    end
  endtask

  // One word built from plain bytes, quoted runs and escapes.
  task automatic add_word();
    logic [7:0] q;
    for (int p = 0; p < $urandom_range(1, 4); p++) begin
      case ($urandom_range(5))
        0, 1: line_bytes.push_back(rand_letter());
        2: begin
          q = $urandom_range(1) ? clt_pkg::CH_DQUOTE : clt_pkg::CH_SQUOTE;
          line_bytes.push_back(q);
          repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(3))
              0: line_bytes.push_back(clt_pkg::CH_SPACE);
              1: line_bytes.push_back(clt_pkg::CH_TAB);
              2: line_bytes.push_back(q == clt_pkg::CH_DQUOTE ? clt_pkg::CH_SQUOTE
                                                              : clt_pkg::CH_DQUOTE);
              default: line_bytes.push_back(rand_letter());
            endcase
          end
          line_bytes.push_back(q);
        end
        3: begin
          line_bytes.push_back(clt_pkg::CH_BSLASH);
          case ($urandom_range(4))
            0: line_bytes.push_back(clt_pkg::CH_LOWER_N);
            1: line_bytes.push_back(clt_pkg::CH_LOWER_R);
            2: repeat ($urandom_range(1, 3)) begin
              line_bytes.push_back(clt_pkg::CH_ZERO + 8'($urandom_range(7)));
            end
            // The digits eight and nine are literal after a backslash.
            3: line_bytes.push_back(clt_pkg::CH_SEVEN + 8'($urandom_range(1, 2)));
            default: line_bytes.push_back(8'($urandom_range(8'h21, 8'hff)));
          endcase
        end
        4: line_bytes.push_back(8'($urandom_range(8'h80, 8'hff)));
        default: line_bytes.push_back(8'($urandom_range(8'h21, 8'h7e)));
      endcase
    end
  endtask

  // Body of a line: optional leading blanks and a few separated words.
  task automatic add_words();
    int n_words;
    n_words = $urandom_range(1, 6);
    if ($urandom_range(3) == 0) add_blanks();
    for (int w = 0; w < n_words; w++) begin
      add_word();
      if (w < n_words - 1 || $urandom_range(3) == 0) add_blanks();
    end
  endtask

  // Random lines until the phase has its share of tokenized requests.
  task automatic random_phase();
    counted_items = 0;
    while (counted_items < PHASE_ITEMS) begin
      case ($urandom_range(19))
        // Noise: any byte, line ends included.
        0, 1, 2: repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(255)));
        // Broken line: cut inside a quote, an escape or an octal run.
        3, 4, 5: begin
          add_words();
          case ($urandom_range(2))
            0: begin
              line_bytes.push_back(clt_pkg::CH_SQUOTE);
              line_bytes.push_back(rand_letter());
            end
            1: line_bytes.push_back(clt_pkg::CH_BSLASH);
            default: begin
              line_bytes.push_back(clt_pkg::CH_BSLASH);
              repeat ($urandom_range(1, 2)) begin
                line_bytes.push_back(clt_pkg::CH_ZERO + 8'($urandom_range(7)));
              end
            end
          endcase
          line_bytes.push_back($urandom_range(3) == 0 ? clt_pkg::CH_NUL : clt_pkg::CH_NL);
        end
        default: begin
          add_words();
          if ($urandom_range(4) == 0) begin
            line_bytes.push_back(clt_pkg::CH_HASH);
            repeat ($urandom_range(0, 4)) line_bytes.push_back(8'($urandom_range(8'h20, 8'hff)));
          end
          line_bytes.push_back($urandom_range(3) == 0 ? clt_pkg::CH_NUL : clt_pkg::CH_NL);
        end
      endcase
      send_line();
    end
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin : receiver
    int hold_left;
    int seen_epoch;
    hold_left = 0;
    seen_epoch = 0;
    forever begin
      @(posedge clk);
      if (hold_epoch != seen_epoch) begin
        seen_epoch = hold_epoch;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else begin
        res_stall <= $urandom_range(99) < recv_idle_pct;
      end
    end
  end

  // Each accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected result: kind %0d value %0h word_count %0d", kind, value, word_count);
        error_count++;
      end else begin
        arrived_want = expected_tokens.pop_front();
        if (kind !== arrived_want.kind) begin
          $error("kind: expected %0d, actual %0d", arrived_want.kind, kind);
          error_count++;
        end
        if (value !== arrived_want.value) begin
          $error("value: expected %0h, actual %0h", arrived_want.value, value);
          error_count++;
        end
        if (word_count !== arrived_want.word_cnt) begin
          $error("word_count: expected %0d, actual %0d", arrived_want.word_cnt, word_count);
          error_count++;
        end
        if (last !== arrived_want.last) begin
          $error("last: expected %0d, actual %0d", arrived_want.last, last);
          error_count++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    // Directed requests; the first rows carry results read off by hand.
    dir_table[0]  = typed_row(clt_pkg::CH_NL, 2'd1,
                              tok(clt_pkg::KIND_LINE_END, 8'h00, 7'd0, 1'b1));
    dir_table[1]  = typed_row("a", 2'd1, tok(clt_pkg::KIND_BYTE, "a", 7'd0, 1'b1));
    dir_table[2]  = typed_row(8'hff, 2'd1, tok(clt_pkg::KIND_BYTE, 8'hff, 7'd0, 1'b1));
    dir_table[3]  = typed_row(clt_pkg::CH_SPACE, 2'd1,
                              tok(clt_pkg::KIND_WORD_END, 8'h00, 7'd0, 1'b1));
    dir_table[4]  = typed_row(clt_pkg::CH_HASH, 2'd0, '0);
    dir_table[5]  = typed_row(clt_pkg::CH_NUL, 2'd1,
                              tok(clt_pkg::KIND_LINE_END, 8'h00, 7'd1, 1'b1));
    // A quoted blank and the newline and carriage return escapes.
    dir_table[6]  = plain_row(clt_pkg::CH_DQUOTE);
    dir_table[7]  = plain_row(clt_pkg::CH_SPACE);
    dir_table[8]  = plain_row(clt_pkg::CH_BSLASH);
    dir_table[9]  = plain_row(clt_pkg::CH_LOWER_N);
    dir_table[10] = plain_row(clt_pkg::CH_DQUOTE);
    dir_table[11] = plain_row(clt_pkg::CH_BSLASH);
    dir_table[12] = plain_row(clt_pkg::CH_LOWER_R);
    // An octal run cut short, a literal eight and a full three-digit run.
    dir_table[13] = plain_row(clt_pkg::CH_BSLASH);
    dir_table[14] = plain_row("1");
    dir_table[15] = plain_row("q");
    dir_table[16] = plain_row(clt_pkg::CH_BSLASH);
    dir_table[17] = plain_row("8");
    dir_table[18] = plain_row(clt_pkg::CH_BSLASH);
    dir_table[19] = plain_row("3");
    dir_table[20] = plain_row("7");
    dir_table[21] = plain_row("7");
    // A hash inside a word, an empty quoted word and an escape cut by the line end.
    dir_table[22] = plain_row(clt_pkg::CH_HASH);
    dir_table[23] = plain_row(clt_pkg::CH_TAB);
    dir_table[24] = plain_row(clt_pkg::CH_SQUOTE);
    dir_table[25] = plain_row(clt_pkg::CH_SQUOTE);
    dir_table[26] = plain_row(clt_pkg::CH_BSLASH);
    dir_table[27] = plain_row(clt_pkg::CH_NL);

    clear_tokenizer();
    send_idle_pct <= 15;
    recv_idle_pct <= 56;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) send_request(dir_table[i]);

    // One line that runs past the word limit, then random lines.
    for (int w = 0; w < MAX_WORDS + 3; w++) begin
      line_bytes.push_back(rand_letter());
      line_bytes.push_back(clt_pkg::CH_SPACE);
    end
    line_bytes.push_back(clt_pkg::CH_NL);
    send_line();
    random_phase();

    send_idle_pct <= 56;
    recv_idle_pct <= 15;
    random_phase();

    // No idling; the receiver holds off while requests keep coming.
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_epoch <= hold_epoch + 1;
    random_phase();

    ch_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/clt_pkg.sv
hw/rtl/clt_front.sv
hw/rtl/clt_queue.sv
hw/rtl/clt_back.sv
hw/rtl/command_line_tokenizer_core.sv
hw/rtl/clt_checker.sv
bench/command_line_tokenizer_core_test.sv
